FILE: rtl/kdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kdc_pkg;

  localparam int QueueDepth = 16;
  localparam int KeyBits    = 32;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_SERVE  = 3'd2,
    FUNC_CANCEL = 3'd3,
    FUNC_SEARCH = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [KeyBits-1:0] visitor_key;
    logic [1:0]         ride_code;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KeyBits-1:0] out_key;
    logic [1:0]         out_ride;
    logic [CntW-1:0]    position;
    logic [CntW-1:0]    occupancy;
  } out_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [1:0]         ride;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               exec;
    logic [2:0]         func;
    logic [CntW-1:0]    cnt;
    logic [KeyBits-1:0] key;
    logic [1:0]         ride;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/kdc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module kdc_cell (
  input  wire logic                     clk_i,
  input  wire logic [kdc_pkg::IdxW-1:0] idx_i,
  input  wire kdc_pkg::cell_ctl_t       ctl_i,
  input  wire kdc_pkg::entry_t          left_i,
  input  wire kdc_pkg::entry_t          right_i,
  input  wire logic                     hit_i,
  output kdc_pkg::entry_t               entry_o,
  output logic                          hit_o,
  output logic                          first_o
);

  kdc_pkg::entry_t entry_q, entry_d, new_entry;
  logic            valid, match;

  assign new_entry = '{key: ctl_i.key, ride: ctl_i.ride};
  assign valid     = {1'b0, idx_i} < ctl_i.cnt;
  assign match     = valid && (entry_q.key == ctl_i.key);
  assign hit_o     = hit_i | match;
  assign first_o   = match & ~hit_i;
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.exec) begin
      case (ctl_i.func)
        kdc_pkg::FUNC_APPEND: begin
          if (ctl_i.cnt == {1'b0, idx_i}) entry_d = new_entry;
        end
        kdc_pkg::FUNC_INSERT: begin
          if (ctl_i.cnt != kdc_pkg::CntW'(kdc_pkg::QueueDepth)) begin
            entry_d = (idx_i == '0) ? new_entry : left_i;
          end
        end
        kdc_pkg::FUNC_SERVE: begin
          if (ctl_i.cnt != '0) entry_d = right_i;
        end
        kdc_pkg::FUNC_CANCEL: begin
          // close the gap from the first match toward the tail
          if (hit_o) entry_d = right_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

FILE: rtl/keyed_deque_with_cancel_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted command word is registered, then executed in S_EXEC once the output
// register is free; its result word is registered there. No new command is taken
// until the last has run its key compare and shift pass through the cell chain.
// Reset: asynchronous, active low; clears the entry count and handshake state.
// Cell contents are not reset; only slots below the count are ever read.
module keyed_deque_with_cancel_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire kdc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output kdc_pkg::out_t      out_data_o
);

  localparam int D = kdc_pkg::QueueDepth;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e                    state_q;
  kdc_pkg::in_t              cmd_q;
  logic [kdc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      out_valid_q;
  kdc_pkg::out_t             out_q, res;
  logic                      out_free, do_exec;

  kdc_pkg::cell_ctl_t        ctl;
  kdc_pkg::entry_t           entry [D];
  kdc_pkg::entry_t           left_a [D];
  kdc_pkg::entry_t           right_a [D];
  logic [D:0]                hit;
  logic [D-1:0]              first;
  kdc_pkg::entry_t           sel_entry;
  logic [kdc_pkg::CntW-1:0]  sel_pos;

  // Output register frees the input side: a new word is taken while a result waits.
  assign out_free    = !out_valid_q || out_ready_i;
  assign do_exec     = (state_q == S_EXEC) && out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ctl = '{exec: do_exec, func: cmd_q.func, cnt: cnt_q,
                 key: cmd_q.visitor_key, ride: cmd_q.ride_code};

  // neighbor links; the ends see an empty entry
  always_comb begin
    for (int i = 0; i < D; i++) begin
      left_a[i]  = (i == 0)     ? '0 : entry[(i == 0) ? 0 : i - 1];
      right_a[i] = (i == D - 1) ? '0 : entry[(i == D - 1) ? i : i + 1];
    end
  end

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < D; g++) begin : g_cell
    kdc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (kdc_pkg::IdxW'(g)),
      .ctl_i   (ctl),
      .left_i  (left_a[g]),
      .right_i (right_a[g]),
      .hit_i   (hit[g]),
      .entry_o (entry[g]),
      .hit_o   (hit[g+1]),
      .first_o (first[g])
    );
  end

  // First match is one-hot, so an OR over the cells picks it out.
  always_comb begin
    sel_entry = '0;
    sel_pos   = '0;
    for (int i = 0; i < D; i++) begin
      if (first[i]) begin
        sel_entry = sel_entry | entry[i];
        sel_pos   = sel_pos | kdc_pkg::CntW'(i + 1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    res   = '0;
    res.status = kdc_pkg::ST_OK;
    case (cmd_q.func)
      kdc_pkg::FUNC_APPEND, kdc_pkg::FUNC_INSERT: begin
        if (cnt_q == kdc_pkg::CntW'(D)) begin
          res.status = kdc_pkg::ST_FULL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      kdc_pkg::FUNC_SERVE: begin
        if (cnt_q == '0) begin
          res.status = kdc_pkg::ST_MISS;
        end else begin
          res.out_key  = entry[0].key;
          res.out_ride = entry[0].ride;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      kdc_pkg::FUNC_CANCEL: begin
        if (!hit[D]) begin
          res.status = kdc_pkg::ST_MISS;
        end else begin
          res.out_key  = sel_entry.key;
          res.out_ride = sel_entry.ride;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      kdc_pkg::FUNC_SEARCH: begin
        if (!hit[D]) begin
          res.status = kdc_pkg::ST_MISS;
        end else begin
          res.out_key  = sel_entry.key;
          res.out_ride = sel_entry.ride;
          res.position = sel_pos;
        end
      end
      default: ;
    endcase
    res.occupancy = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a taken result word clears valid unless a new one lands this cycle
      if (out_ready_i && !do_exec) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            cnt_q       <= cnt_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_data_i;
    if (do_exec) out_q <= res;
  end

endmodule
`default_nettype wire
